@@ hw/rtl/fbv_pkg.sv @@
// ----------------------------------------------------------------------------
// fbv_pkg
// Shared types, constants and plane corner table for the frustum box test.
// ----------------------------------------------------------------------------
package fbv_pkg;

  localparam int CoordWidthDefault = 16;
  localparam int NumCorners        = 8;
  localparam int NumPlanes         = 6;
  localparam int NumPoints         = 9;
  localparam int SumWidth          = 64;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_QUERY,
    ST_DONE
  } state_t;

  typedef logic [SumWidth-1:0] wide_t;

  function automatic logic [2:0] plane_corner(input logic [2:0] k, input logic [1:0] j);
    logic [2:0] r;
    r = 3'd0;
    case (k)
      3'd0: r = (j == 2'd0) ? 3'd0 : (j == 2'd1) ? 3'd2 : 3'd1;
      3'd1: r = (j == 2'd0) ? 3'd4 : (j == 2'd1) ? 3'd5 : 3'd6;
      3'd2: r = (j == 2'd0) ? 3'd3 : (j == 2'd1) ? 3'd7 : 3'd6;
      3'd3: r = (j == 2'd0) ? 3'd0 : (j == 2'd1) ? 3'd5 : 3'd4;
      3'd4: r = (j == 2'd0) ? 3'd3 : (j == 2'd1) ? 3'd4 : 3'd7;
      3'd5: r = (j == 2'd0) ? 3'd2 : (j == 2'd1) ? 3'd6 : 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/fbv_plane_cell.sv @@
// ----------------------------------------------------------------------------
// fbv_plane_cell
// One cell of the plane chain: holds one plane and tests the passing point.
// A point enters with a pass flag; the cell clears the flag on a miss.
// Two register stages: plane products, then the plane test.
// ----------------------------------------------------------------------------
module fbv_plane_cell #(
  parameter int COORD_WIDTH = fbv_pkg::CoordWidthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic signed [2*COORD_WIDTH+2:0] nx_in,
  input  logic signed [2*COORD_WIDTH+2:0] ny_in,
  input  logic signed [2*COORD_WIDTH+2:0] nz_in,
  input  fbv_pkg::wide_t                  d_in,
  input  logic signed [COORD_WIDTH:0]     px_in,
  input  logic signed [COORD_WIDTH:0]     py_in,
  input  logic signed [COORD_WIDTH:0]     pz_in,
  input  logic                            dbl_in,
  input  logic                            pass_in,
  output logic signed [COORD_WIDTH:0]     px_out,
  output logic signed [COORD_WIDTH:0]     py_out,
  output logic signed [COORD_WIDTH:0]     pz_out,
  output logic                            dbl_out,
  output logic                            pass_out
);
  import fbv_pkg::*;
  localparam int W  = COORD_WIDTH;
  localparam int NW = 2*W + 3;
  localparam int PW = NW + W + 1;

  logic signed [NW-1:0] nx, ny, nz;
  wide_t                d;
  logic signed [PW-1:0] prx, pry, prz;
  logic signed [W:0]    sx, sy, sz;
  logic                 sdbl, spass;
  wide_t                dot, rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= '0;
      ny <= '0;
      nz <= '0;
      d  <= '0;
    end else if (load) begin
      nx <= nx_in;
      ny <= ny_in;
      nz <= nz_in;
      d  <= d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prx <= '0;
      pry <= '0;
      prz <= '0;
      sx <= '0;
      sy <= '0;
      sz <= '0;
      sdbl <= 1'b0;
      spass <= 1'b0;
      px_out <= '0;
      py_out <= '0;
      pz_out <= '0;
      dbl_out <= 1'b0;
      pass_out <= 1'b0;
    end else begin
      prx <= nx * px_in;
      pry <= ny * py_in;
      prz <= nz * pz_in;
      sx <= px_in;
      sy <= py_in;
      sz <= pz_in;
      sdbl <= dbl_in;
      spass <= pass_in;
      px_out <= sx;
      py_out <= sy;
      pz_out <= sz;
      dbl_out <= sdbl;
      pass_out <= spass & ($signed(dot) >= $signed(rhs));
    end
  end

  assign dot = wide_t'(prx) + wide_t'(pry) + wide_t'(prz);
  assign rhs = sdbl ? (d << 1) : d;
endmodule

@@ hw/rtl/frustum_box_visibility_test.sv @@
// ----------------------------------------------------------------------------
// frustum_box_visibility_test
// Frustum from eight corners, axis-aligned box visibility test.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tuser=action, tdata=index,corner xyz,box min xyz,box max xyz
// m_axis   out  tdata=in_view,coarse_overlap,frustum_complete
// Load: accept, then per plane the normal is registered, then loaded into its cell;
// box folds one corner a cycle. Query: accept, 9 points enter the 6-cell chain one
// per cycle, result when the last point leaves; no box overlap gives it next cycle.
// One item at a time; s_axis_tready low while busy or a result waits.
// rst clears corners, planes, box and loaded mask.
module frustum_box_visibility_test #(
  parameter int COORD_WIDTH = fbv_pkg::CoordWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // index[2:0], cx, cy, cz, bminx, bminy, bminz, bmaxx, bmaxy, bmaxz
  input  logic [((3+9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                     s_axis_tuser, // action
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata  // in_view, coarse_overlap, frustum_complete
);
  import fbv_pkg::*;
  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int NW = 2*DW + 1;
  localparam logic [3:0] BsLast  = 4'(2*NumPlanes - 1);
  localparam logic [3:0] BsBox   = 4'(NumCorners);
  localparam logic [4:0] QcFeed  = 5'(NumPoints);
  localparam logic [4:0] QcDrain = 5'(2*NumPlanes);
  localparam logic [4:0] QcLast  = 5'(NumPoints + 2*NumPlanes - 1);

  state_t state, state_next;
  logic [W-1:0] cs [NumCorners][3];
  logic [7:0]   loaded;
  logic [W-1:0] blo [3], bhi [3];
  logic signed [W-1:0] bmn [3], bmx [3];
  logic [3:0] bs;
  logic [4:0] qc;
  logic [2:0] res;

  function automatic wide_t sx(input logic [W-1:0] v);
    return wide_t'($signed(v));
  endfunction

  // plane build: normal and anchor corner registered, then loaded into the plane's cell
  logic signed [W-1:0]    a [3], b [3], c [3];
  logic signed [DW-1:0]   u [3], v [3];
  logic signed [2*DW-1:0] m [6];
  logic signed [NW-1:0]   n [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = cs[plane_corner(bs[3:1], 2'd0)][i];
      b[i] = cs[plane_corner(bs[3:1], 2'd1)][i];
      c[i] = cs[plane_corner(bs[3:1], 2'd2)][i];
      u[i] = DW'(b[i]) - DW'(a[i]);
      v[i] = DW'(c[i]) - DW'(a[i]);
    end
    m[0] = u[1] * v[2];
    m[1] = u[2] * v[1];
    m[2] = u[2] * v[0];
    m[3] = u[0] * v[2];
    m[4] = u[0] * v[1];
    m[5] = u[1] * v[0];
    n[0] = NW'(m[0]) - NW'(m[1]);
    n[1] = NW'(m[2]) - NW'(m[3]);
    n[2] = NW'(m[4]) - NW'(m[5]);
  end

  logic signed [NW-1:0]   bn [3];
  logic signed [W-1:0]    ba [3];
  logic signed [NW+W-1:0] op [3];
  wide_t off;
  always_comb begin
    for (int i = 0; i < 3; i++) op[i] = bn[i] * ba[i];
    off = wide_t'(op[0]) + wide_t'(op[1]) + wide_t'(op[2]);
  end

  // query point: centre doubled first, then the eight corners
  logic [2:0] cidx;
  logic signed [DW-1:0] p [3];
  logic dbl, inject;
  always_comb begin
    cidx = 3'(qc - 5'd1);
    dbl = (qc == 5'd0);
    for (int i = 0; i < 3; i++)
      p[i] = dbl ? (DW'(bmn[i]) + DW'(bmx[i])) : (cidx[i] ? DW'(bmx[i]) : DW'(bmn[i]));
  end
  assign inject = (state == ST_QUERY) && (qc < QcFeed);

  logic signed [DW-1:0] lx [NumPlanes+1], ly [NumPlanes+1], lz [NumPlanes+1];
  logic ldbl [NumPlanes+1], lpass [NumPlanes+1];
  logic [NumPlanes-1:0] cell_load;

  assign lx[0] = p[0];
  assign ly[0] = p[1];
  assign lz[0] = p[2];
  assign ldbl[0] = dbl;
  assign lpass[0] = inject;

  for (genvar k = 0; k < NumPlanes; k++) begin : g_cell
    assign cell_load[k] = (state == ST_BUILD) && bs[0] && (bs[3:1] == 3'(k));
    fbv_plane_cell #(.COORD_WIDTH(W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (cell_load[k]),
      .nx_in    (bn[0]),
      .ny_in    (bn[1]),
      .nz_in    (bn[2]),
      .d_in     (off),
      .px_in    (lx[k]),
      .py_in    (ly[k]),
      .pz_in    (lz[k]),
      .dbl_in   (ldbl[k]),
      .pass_in  (lpass[k]),
      .px_out   (lx[k+1]),
      .py_out   (ly[k+1]),
      .pz_out   (lz[k+1]),
      .dbl_out  (ldbl[k+1]),
      .pass_out (lpass[k+1])
    );
  end

  logic ov;
  always_comb begin
    ov = 1'b1;
    for (int i = 0; i < 3; i++) begin
      wide_t mn, mx, lo, hi;
      mn = sx(s_axis_tdata[3+(3+i)*W +: W]);
      mx = sx(s_axis_tdata[3+(6+i)*W +: W]);
      lo = ($signed(sx(blo[i])) > $signed(mn)) ? sx(blo[i]) : mn;
      hi = ($signed(sx(bhi[i])) < $signed(mx)) ? sx(bhi[i]) : mx;
      if ($signed(lo) > $signed(hi)) ov = 1'b0;
    end
  end

  logic acc;
  assign s_axis_tready = (state == ST_IDLE);
  assign acc = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = (state == ST_DONE);
  assign m_axis_tdata = {5'd0, res};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (acc) state_next = (s_axis_tuser == ACT_QUERY) ? (ov ? ST_QUERY : ST_DONE)
                                                                    : ST_BUILD;
      ST_BUILD: if (bs == BsLast) state_next = ST_IDLE;
      ST_QUERY: if (qc == QcLast) state_next = ST_DONE;
      ST_DONE:  if (m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      loaded <= 8'd0;
      for (int k = 0; k < NumCorners; k++)
        for (int i = 0; i < 3; i++) cs[k][i] <= '0;
      for (int i = 0; i < 3; i++) begin
        blo[i] <= '0;
        bhi[i] <= '0;
        bmn[i] <= '0;
        bmx[i] <= '0;
        bn[i] <= '0;
        ba[i] <= '0;
      end
      bs <= 4'd0; qc <= 5'd0; res <= 3'd0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: if (acc) begin
          bs <= 4'd0; qc <= 5'd0;
          if (s_axis_tuser == ACT_LOAD) begin
            for (int i = 0; i < 3; i++)
              cs[s_axis_tdata[2:0]][i] <= s_axis_tdata[3+i*W +: W];
            loaded[s_axis_tdata[2:0]] <= 1'b1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              bmn[i] <= s_axis_tdata[3+(3+i)*W +: W];
              bmx[i] <= s_axis_tdata[3+(6+i)*W +: W];
            end
            res <= {&loaded, ov, 1'b0};
          end
        end
        ST_BUILD: begin
          if (!bs[0]) begin
            for (int i = 0; i < 3; i++) begin
              bn[i] <= n[i];
              ba[i] <= a[i];
            end
          end
          for (int i = 0; i < 3; i++) begin
            if (bs == 4'd0) begin
              blo[i] <= cs[0][i];
              bhi[i] <= cs[0][i];
            end else if (bs < BsBox) begin
              if ($signed(cs[bs[2:0]][i]) < $signed(blo[i])) blo[i] <= cs[bs[2:0]][i];
              if ($signed(cs[bs[2:0]][i]) > $signed(bhi[i])) bhi[i] <= cs[bs[2:0]][i];
            end
          end
          bs <= bs + 4'd1;
        end
        ST_QUERY: begin
          if (qc >= QcDrain && lpass[NumPlanes]) res[0] <= 1'b1;
          qc <= qc + 5'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ tb/frustum_box_visibility_test_chk.sv @@
// ----------------------------------------------------------------------------
// frustum_box_visibility_test_chk
// Watches both channels of the frustum box test, keeps its own frustum
// state, predicts each query result and compares it with the output item.
// ----------------------------------------------------------------------------
module frustum_box_visibility_test_chk #(
  parameter int CW = 16,
  parameter int DW = ((3+9*CW+7)/8)*8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [DW-1:0] s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [7:0]    m_axis_tdata,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbv_pkg::*;

  typedef logic signed [63:0] s64_t;
  typedef struct packed {
    logic in_view;
    logic coarse_overlap;
    logic frustum_complete;
  } verdict_t;

  s64_t     corner [8][3];
  s64_t     normal [6][3];
  s64_t     offset [6];
  s64_t     box_lo [3];
  s64_t     box_hi [3];
  logic [7:0] loaded;
  verdict_t verdicts [$];

  function automatic s64_t field(input logic [DW-1:0] d, input int k);
    return s64_t'(signed'(d[3+k*CW +: CW]));
  endfunction

  function automatic logic point_ok(input s64_t p [3], input s64_t s);
    s64_t dot;
    for (int k = 0; k < 6; k++) begin
      dot = normal[k][0]*p[0] + normal[k][1]*p[1] + normal[k][2]*p[2];
      if (dot < s*offset[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic rebuild_frustum();
    int plane_pts [6][3] = '{'{0,2,1},'{4,5,6},'{3,7,6},'{0,5,4},'{3,4,7},'{2,6,5}};
    s64_t u [3];
    s64_t v [3];
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        u[i] = corner[plane_pts[k][1]][i] - corner[plane_pts[k][0]][i];
        v[i] = corner[plane_pts[k][2]][i] - corner[plane_pts[k][0]][i];
      end
      normal[k][0] = u[1]*v[2] - u[2]*v[1];
      normal[k][1] = u[2]*v[0] - u[0]*v[2];
      normal[k][2] = u[0]*v[1] - u[1]*v[0];
      offset[k] = normal[k][0]*corner[plane_pts[k][0]][0]
                + normal[k][1]*corner[plane_pts[k][0]][1]
                + normal[k][2]*corner[plane_pts[k][0]][2];
    end
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = corner[0][i];
      box_hi[i] = corner[0][i];
      for (int c = 1; c < 8; c++) begin
        if (corner[c][i] < box_lo[i]) box_lo[i] = corner[c][i];
        if (corner[c][i] > box_hi[i]) box_hi[i] = corner[c][i];
      end
    end
  endtask

  task automatic apply_item(input logic act, input logic [DW-1:0] d);
    s64_t bmin [3];
    s64_t bmax [3];
    s64_t p [3];
    s64_t lo, hi;
    verdict_t r;
    int idx;
    if (action_t'(act) == ACT_LOAD) begin
      idx = d[2:0];
      for (int i = 0; i < 3; i++) corner[idx][i] = field(d, i);
      loaded[idx] = 1'b1;
      rebuild_frustum();
      return;
    end
    r.coarse_overlap = 1'b1;
    for (int i = 0; i < 3; i++) begin
      bmin[i] = field(d, 3+i);
      bmax[i] = field(d, 6+i);
      lo = (box_lo[i] > bmin[i]) ? box_lo[i] : bmin[i];
      hi = (box_hi[i] < bmax[i]) ? box_hi[i] : bmax[i];
      if (lo > hi) r.coarse_overlap = 1'b0;
      p[i] = bmin[i] + bmax[i];
    end
    r.in_view = 1'b0;
    if (r.coarse_overlap) begin
      r.in_view = point_ok(p, 2);
      for (int c = 0; c < 8 && !r.in_view; c++) begin
        for (int i = 0; i < 3; i++) p[i] = c[i] ? bmax[i] : bmin[i];
        r.in_view = point_ok(p, 1);
      end
    end
    r.frustum_complete = &loaded;
    verdicts.push_back(r);
  endtask

  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      for (int c = 0; c < 8; c++) for (int i = 0; i < 3; i++) corner[c][i] = '0;
      loaded = '0;
      rebuild_frustum();
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result item %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = verdicts.pop_front();
          if (m_axis_tdata[0] !== e.in_view ||
              m_axis_tdata[1] !== e.coarse_overlap ||
              m_axis_tdata[2] !== e.frustum_complete) begin
            if (m_axis_tdata[0] !== e.in_view)
              $error("in_view expected %b got %b", e.in_view, m_axis_tdata[0]);
            if (m_axis_tdata[1] !== e.coarse_overlap)
              $error("coarse_overlap expected %b got %b", e.coarse_overlap,
                     m_axis_tdata[1]);
            if (m_axis_tdata[2] !== e.frustum_complete)
              $error("frustum_complete expected %b got %b", e.frustum_complete,
                     m_axis_tdata[2]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_item(s_axis_tuser, s_axis_tdata);
    end
    pending <= verdicts.size();
  end
endmodule

@@ tb/frustum_box_visibility_test_tb.sv @@
// ----------------------------------------------------------------------------
// frustum_box_visibility_test_tb
// Drives frustum corner loads and box queries with random gaps and output
// stalls; the checker predicts each verdict and counts mismatches.
// ----------------------------------------------------------------------------
module frustum_box_visibility_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbv_pkg::*;

  localparam int CW = 16;
  localparam int DW = ((3+9*CW+7)/8)*8;
  localparam int IdleLimit = 2000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [7:0]    m_axis_tdata;
  int            fail_count;
  int            pending;
  int            idle_cycles = 0;
  logic [15:0]   fr [8][3];

  always #4 clk = ~clk;

  frustum_box_visibility_test #(.COORD_WIDTH(CW)) dut (.*);
  frustum_box_visibility_test_chk #(.CW(CW)) chk (.*);

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall before each result, sometimes none at all.
  initial begin
    int w;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w != 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input action_t act, input logic [DW-1:0] d, input int gap);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic load_corner(input logic [2:0] idx, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
    logic [DW-1:0] d;
    d = '0;
    d[2:0] = idx;
    d[3 +: 48] = {z, y, x};
    send_item(ACT_LOAD, d, rand_gap());
  endtask

  task automatic query_box(input logic [15:0] lo [3], input logic [15:0] hi [3]);
    logic [DW-1:0] d;
    d = DW'($urandom());
    for (int i = 0; i < 3; i++) begin
      d[3+(3+i)*CW +: CW] = lo[i];
      d[3+(6+i)*CW +: CW] = hi[i];
    end
    send_item(ACT_QUERY, d, rand_gap());
  endtask

  function automatic logic [15:0] near_coord(input int spread);
    return 16'($signed($urandom_range(0, 2*spread)) - spread);
  endfunction

  task automatic random_frustum();
    int s, h, f;
    logic [15:0] cx, cy, cz;
    s = $urandom_range(1, 2000);
    f = s + $urandom_range(1, 12000);
    h = $urandom_range(0, 3000);
    cx = near_coord(8000);
    cy = near_coord(8000);
    cz = near_coord(8000);
    for (int c = 0; c < 8; c++) begin
      fr[c][0] = cx + 16'(((c % 4) inside {1, 2}) ? ((c < 4) ? s : f) : -((c < 4) ? s : f));
      fr[c][1] = cy + 16'((c % 4 >= 2) ? ((c < 4) ? s : f) : -((c < 4) ? s : f));
      fr[c][2] = cz + 16'((c < 4) ? 0 : h + 100);
      fr[c][$urandom_range(0, 2)] += 16'($urandom_range(0, 6));
    end
  endtask

  task automatic random_query(input int wide);
    logic [15:0] lo [3];
    logic [15:0] hi [3];
    int c;
    c = $urandom_range(0, 7);
    for (int i = 0; i < 3; i++) begin
      if (wide) begin
        lo[i] = 16'($urandom());
        hi[i] = 16'($urandom());
      end else begin
        lo[i] = fr[c][i] + near_coord(3000);
        hi[i] = lo[i] + 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 15) == 0) {lo[i], hi[i]} = {hi[i], lo[i]};
      end
    end
    query_box(lo, hi);
  endtask

  initial begin
    logic [15:0] lo [3];
    logic [15:0] hi [3];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Query on an empty frustum, then partial loads.
    lo = '{16'h8000, 16'h8000, 16'h8000};
    hi = '{16'h7fff, 16'h7fff, 16'h7fff};
    query_box(lo, hi);
    lo = '{16'h0001, 16'h0000, 16'h0000};
    hi = '{16'h0000, 16'h0000, 16'h0000};
    query_box(lo, hi);
    load_corner(3'd0, 16'h8000, 16'h8000, 16'h8000);
    load_corner(3'd7, 16'h7fff, 16'h7fff, 16'h7fff);
    query_box(lo, hi);
    lo = '{16'h0000, 16'h0000, 16'h0000};
    query_box(lo, hi);
    // Extreme cube frustum.
    for (int c = 0; c < 8; c++)
      load_corner(c[2:0], (c % 4 inside {1, 2}) ? 16'h7fff : 16'h8000,
                  (c % 4 >= 2) ? 16'h7fff : 16'h8000, c[2] ? 16'h7fff : 16'h8000);
    lo = '{16'h8000, 16'h8000, 16'h8000};
    hi = '{16'h7fff, 16'h7fff, 16'h7fff};
    query_box(lo, hi);
    query_box(hi, hi);
    query_box(hi, lo);
    lo = '{16'hffff, 16'h0000, 16'h0001};
    query_box(lo, lo);
    // Collinear corners give degenerate planes.
    for (int c = 0; c < 8; c++) load_corner(c[2:0], 16'(c * 10), 16'(c * 10), 16'(c * 10));
    lo = '{16'h0000, 16'h0000, 16'h0000};
    hi = '{16'h0005, 16'h0005, 16'h0005};
    query_box(lo, hi);
    hi = '{16'h7000, 16'h0000, 16'h0000};
    query_box(hi, hi);

    for (int n = 0; n < 120; n++) begin
      random_frustum();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 7)) begin
          load_corner(3'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
          random_query(1);
        end
      end else begin
        for (int c = 0; c < 8; c++) load_corner(c[2:0], fr[c][0], fr[c][1], fr[c][2]);
      end
      repeat ($urandom_range(2, 5)) random_query($urandom_range(0, 7) == 0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/fbv_pkg.sv
hw/rtl/fbv_plane_cell.sv
hw/rtl/frustum_box_visibility_test.sv
tb/frustum_box_visibility_test_chk.sv
tb/frustum_box_visibility_test_tb.sv
